### hdl/tsukamoto_fuzzy_inference_assert.svh
// Assertion macros for the fuzzy inference RTL.
`ifndef TSUKAMOTO_FUZZY_INFERENCE_ASSERT_SVH
`define TSUKAMOTO_FUZZY_INFERENCE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TFI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TFI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tfi_pkg.sv
package tfi_pkg;

    // Field widths.
    localparam int DW = 16;
    localparam int GF = 16;
    localparam int GW = GF + 1;

    // Configuration register indexes.
    localparam int NUM_REGS    = 6;
    localparam int CFG_IDX_W   = 3;
    localparam logic [CFG_IDX_W-1:0] REG_DEMAND_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEMAND_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOCK_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOCK_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PROD_MIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PROD_MAX    = 3'd5;

    // Reset values of the registers.
    localparam logic [DW-1:0] RST_DEMAND_LOW  = 16'd500;
    localparam logic [DW-1:0] RST_DEMAND_HIGH = 16'd6000;
    localparam logic [DW-1:0] RST_STOCK_LOW   = 16'd200;
    localparam logic [DW-1:0] RST_STOCK_HIGH  = 16'd800;
    localparam logic [DW-1:0] RST_PROD_MIN    = 16'd3000;
    localparam logic [DW-1:0] RST_PROD_MAX    = 16'd9000;

    localparam logic [GW-1:0] GRADE_ONE = {1'b1, {GF{1'b0}}};

    typedef struct packed {
        logic [DW-1:0] demand;
        logic [DW-1:0] stock;
    } t_in;

    typedef struct packed {
        logic [DW-1:0] production;
        logic [GW-1:0] strength_fall_plenty;
        logic [GW-1:0] strength_fall_scarce;
        logic [GW-1:0] strength_rise_plenty;
        logic [GW-1:0] strength_rise_scarce;
        logic          weight_zero;
    } t_out;

endpackage

### hdl/tsukamoto_fuzzy_inference.sv
// Two-input, four-rule Tsukamoto fuzzy inference engine.
// Input channel: i_in_valid / o_in_stall carry one beat with demand and stock.
// Output channel: o_out_valid / i_out_stall carry one beat with the production
// amount, the four rule strengths (Q1.16) and the zero-weight flag.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_index at the
// clock edge; indexes beyond the six registers are ignored. Write only while
// the engine is empty.
// Throughput is one beat per cycle while the skid register is empty. From input
// to output a beat passes one entry stage, 16 bit-steps of the membership
// dividers, one rule stage, four multiply and sum stages, 16 bit-steps of the
// averaging divider and the output register.
// When the receiver stalls, the result holds in the output register and one
// more beat lands in a skid register; while the skid register is full the
// pipeline freezes and o_in_stall is high. Nothing is dropped or repeated.
// Reset (synchronous, active low) empties the pipeline and loads the register
// reset values.
module tsukamoto_fuzzy_inference (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  tfi_pkg::t_in               i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output tfi_pkg::t_out              o_out_data,
    input  logic                       i_cfg_we,
    input  logic [tfi_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tfi_pkg::DW-1:0]     i_cfg_wdata
);
    import tfi_pkg::*;

    `include "tsukamoto_fuzzy_inference_assert.svh"

    localparam int ZW = DW + GF;
    localparam int PW = DW + GF + GW;
    localparam int NW = PW + 2;
    localparam int SW = GW + 2;

    // Membership divider stage: index 0 demand fall, 1 demand rise,
    // 2 stock scarce, 3 stock plenty.
    typedef struct packed {
        logic [3:0][DW-1:0] rem;
        logic [1:0][DW-1:0] dv;
        logic [3:0][GF-1:0] q;
        logic [1:0]         mid;
        logic [3:0][GW-1:0] fx;
    } t_gs;

    typedef struct packed {
        logic [3:0][GW-1:0] r;
        logic [SW-1:0]      s;
    } t_rs;

    typedef struct packed {
        logic [3:0][GW-1:0] r;
        logic [SW-1:0]      s;
        logic [3:0][ZW-1:0] v;
    } t_ms;

    typedef struct packed {
        logic [3:0][GW-1:0] r;
        logic [SW-1:0]      s;
        logic [3:0][PW-1:0] p;
    } t_ps;

    typedef struct packed {
        logic [3:0][GW-1:0] r;
        logic [SW-1:0]      s;
        logic [SW-1:0]      rem;
        logic [DW-1:0]      nlo;
        logic [DW-1:0]      q;
        logic               zero;
    } t_ds;

    logic [DW-1:0] r_cfg [NUM_REGS];

    t_gs  r_g  [GF+1];
    logic r_gv [GF+1];
    t_gs  n_g  [GF+1];
    t_rs  r_rs, n_rs;
    t_ms  r_m, n_m;
    t_ms  r_z, n_z;
    t_ps  r_p, n_p;
    logic r_rsv, r_mv, r_zv, r_pv;
    t_ds  r_d  [DW+1];
    logic r_dv [DW+1];
    t_ds  n_d  [DW+1];

    t_out r_out, r_skid, n_res;
    logic r_out_valid, r_skid_valid;
    logic en;
    logic accept;
    logic push;
    logic take;

    // One restoring step of the four membership dividers.
    function automatic t_gs f_gstep(t_gs a);
        t_gs b;
        logic [DW:0] t;
        b = a;
        for (int i = 0; i < 4; i++) begin
            t = {a.rem[i], 1'b0};
            if (t >= {1'b0, a.dv[i >> 1]}) begin
                t = t - {1'b0, a.dv[i >> 1]};
                b.q[i] = {a.q[i][GF-2:0], 1'b1};
            end else begin
                b.q[i] = {a.q[i][GF-2:0], 1'b0};
            end
            b.rem[i] = t[DW-1:0];
        end
        return b;
    endfunction

    // One restoring step of the averaging divider.
    function automatic t_ds f_dstep(t_ds a);
        t_ds b;
        logic [SW:0] t;
        b = a;
        t = {a.rem, a.nlo[DW-1]};
        if (t >= {1'b0, a.s}) begin
            t = t - {1'b0, a.s};
            b.q = {a.q[DW-2:0], 1'b1};
        end else begin
            b.q = {a.q[DW-2:0], 1'b0};
        end
        b.rem = t[SW-1:0];
        b.nlo = {a.nlo[DW-2:0], 1'b0};
        return b;
    endfunction

    function automatic logic [GW-1:0] f_min(logic [GW-1:0] a, logic [GW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    assign en     = !r_skid_valid;
    assign accept = i_in_valid && en;
    assign take   = r_out_valid && !i_out_stall;
    assign push   = r_dv[DW] && en;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_DEMAND_LOW]  <= RST_DEMAND_LOW;
            r_cfg[REG_DEMAND_HIGH] <= RST_DEMAND_HIGH;
            r_cfg[REG_STOCK_LOW]   <= RST_STOCK_LOW;
            r_cfg[REG_STOCK_HIGH]  <= RST_STOCK_HIGH;
            r_cfg[REG_PROD_MIN]    <= RST_PROD_MIN;
            r_cfg[REG_PROD_MAX]    <= RST_PROD_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DEMAND_LOW:  r_cfg[REG_DEMAND_LOW]  <= i_cfg_wdata;
                REG_DEMAND_HIGH: r_cfg[REG_DEMAND_HIGH] <= i_cfg_wdata;
                REG_STOCK_LOW:   r_cfg[REG_STOCK_LOW]   <= i_cfg_wdata;
                REG_STOCK_HIGH:  r_cfg[REG_STOCK_HIGH]  <= i_cfg_wdata;
                REG_PROD_MIN:    r_cfg[REG_PROD_MIN]    <= i_cfg_wdata;
                REG_PROD_MAX:    r_cfg[REG_PROD_MAX]    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Entry stage: classify each value against its breakpoints and set up
    // the divider operands for values that lie strictly between them; the divider bit-steps follow.
    always_comb begin
        logic [1:0][DW-1:0] x, lo, hi;
        x[0]  = i_in_data.demand;
        x[1]  = i_in_data.stock;
        lo[0] = r_cfg[REG_DEMAND_LOW];
        hi[0] = r_cfg[REG_DEMAND_HIGH];
        lo[1] = r_cfg[REG_STOCK_LOW];
        hi[1] = r_cfg[REG_STOCK_HIGH];
        n_g[0] = '0;
        for (int v = 0; v < 2; v++) begin
            if (x[v] <= lo[v]) begin
                n_g[0].fx[2*v]   = GRADE_ONE;
                n_g[0].fx[2*v+1] = '0;
            end else if (x[v] >= hi[v]) begin
                n_g[0].fx[2*v]   = '0;
                n_g[0].fx[2*v+1] = GRADE_ONE;
            end else begin
                n_g[0].mid[v]     = 1'b1;
                n_g[0].rem[2*v]   = hi[v] - x[v];
                n_g[0].rem[2*v+1] = x[v] - lo[v];
                n_g[0].dv[v]      = hi[v] - lo[v];
            end
        end
        for (int k = 0; k < GF; k++) begin
            n_g[k+1] = f_gstep(r_g[k]);
        end
    end

    // Rule stage: grades, pairwise minimums and their sum.
    always_comb begin
        logic [3:0][GW-1:0] g;
        for (int i = 0; i < 4; i++) begin
            g[i] = r_g[GF].mid[i >> 1] ? {1'b0, r_g[GF].q[i]} : r_g[GF].fx[i];
        end
        n_rs.r[0] = f_min(g[0], g[3]);
        n_rs.r[1] = f_min(g[0], g[2]);
        n_rs.r[2] = f_min(g[1], g[3]);
        n_rs.r[3] = f_min(g[1], g[2]);
        n_rs.s = SW'(n_rs.r[0]) + SW'(n_rs.r[1]) + SW'(n_rs.r[2]) + SW'(n_rs.r[3]);
    end

    // Span times strength.
    always_comb begin
        logic [DW-1:0] d;
        logic [DW+GW-1:0] prod;
        logic [DW-1:0] pmin, pmax;
        pmin = r_cfg[REG_PROD_MIN];
        pmax = r_cfg[REG_PROD_MAX];
        d = (pmax >= pmin) ? (pmax - pmin) : (pmin - pmax);
        n_m.r = r_rs.r;
        n_m.s = r_rs.s;
        for (int i = 0; i < 4; i++) begin
            prod = d * r_rs.r[i];
            n_m.v[i] = prod[ZW-1:0];
        end
    end

    // Rule outputs, scaled by one grade unit: falling rules start at the
    // maximum, rising rules at the minimum.
    always_comb begin
        logic [ZW-1:0] bmax, bmin;
        logic up;
        bmax = {r_cfg[REG_PROD_MAX], {GF{1'b0}}};
        bmin = {r_cfg[REG_PROD_MIN], {GF{1'b0}}};
        up = r_cfg[REG_PROD_MAX] >= r_cfg[REG_PROD_MIN];
        n_z.r = r_m.r;
        n_z.s = r_m.s;
        for (int i = 0; i < 2; i++) begin
            n_z.v[i]   = up ? (bmax - r_m.v[i]) : (bmax + r_m.v[i]);
            n_z.v[i+2] = up ? (bmin + r_m.v[i+2]) : (bmin - r_m.v[i+2]);
        end
    end

    // Weighted rule outputs.
    always_comb begin
        n_p.r = r_z.r;
        n_p.s = r_z.s;
        for (int i = 0; i < 4; i++) begin
            n_p.p[i] = r_z.v[i] * r_z.r[i];
        end
    end

    // Numerator with half the denominator added for rounding; the grade
    // scale is dropped from both sides before the quotient steps.
    always_comb begin
        logic [NW-1:0] num;
        logic [NW-GF-1:0] nhi;
        num = NW'(r_p.p[0]) + NW'(r_p.p[1]) + NW'(r_p.p[2]) + NW'(r_p.p[3])
            + NW'({r_p.s, {(GF-1){1'b0}}});
        nhi = num[NW-1:GF];
        n_d[0].r    = r_p.r;
        n_d[0].s    = r_p.s;
        n_d[0].rem  = nhi[NW-GF-1:DW];
        n_d[0].nlo  = nhi[DW-1:0];
        n_d[0].q    = '0;
        n_d[0].zero = (r_p.s == '0);
        for (int k = 0; k < DW; k++) begin
            n_d[k+1] = f_dstep(r_d[k]);
        end
    end

    // Result beat from the last divider stage.
    always_comb begin
        n_res.production           = r_d[DW].zero ? '0 : r_d[DW].q;
        n_res.strength_fall_plenty = r_d[DW].r[0];
        n_res.strength_fall_scarce = r_d[DW].r[1];
        n_res.strength_rise_plenty = r_d[DW].r[2];
        n_res.strength_rise_scarce = r_d[DW].r[3];
        n_res.weight_zero          = r_d[DW].zero;
    end

    // Pipeline data, advanced together while the skid register is empty.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g[0] <= n_g[0];
            for (int k = 1; k <= GF; k++) begin
                r_g[k] <= n_g[k];
            end
            r_rs <= n_rs;
            r_m  <= n_m;
            r_z  <= n_z;
            r_p  <= n_p;
            for (int k = 0; k <= DW; k++) begin
                r_d[k] <= n_d[k];
            end
        end
    end

    // Valid bits traveling with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= GF; k++) begin
                r_gv[k] <= 1'b0;
            end
            r_rsv <= 1'b0;
            r_mv  <= 1'b0;
            r_zv  <= 1'b0;
            r_pv  <= 1'b0;
            for (int k = 0; k <= DW; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (en) begin
            r_gv[0] <= i_in_valid;
            for (int k = 1; k <= GF; k++) begin
                r_gv[k] <= r_gv[k-1];
            end
            r_rsv   <= r_gv[GF];
            r_mv    <= r_rsv;
            r_zv    <= r_mv;
            r_pv    <= r_zv;
            r_dv[0] <= r_pv;
            for (int k = 1; k <= DW; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= push;
            end
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (push) begin
            r_skid <= n_res;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `TFI_ASSERT_IMP(a_skid_behind_out, r_skid_valid, r_out_valid, "skid full with empty output")
    `TFI_ASSERT_NXT(a_accept_enters, accept, r_gv[0], "accepted beat did not enter")
    `TFI_ASSERT_NXT(a_result_held, r_out_valid && i_out_stall, r_out_valid, "stalled result lost")
    `TFI_ASSERT_IMP(a_zero_flag, r_out_valid && r_out.weight_zero,
        r_out.production == '0 && r_out.strength_fall_plenty == '0, "zero weight with data")

endmodule

### sim/tb_tsukamoto_fuzzy_inference.sv
`timescale 1ns / 1ps

module tb_tsukamoto_fuzzy_inference;
    import tfi_pkg::*;

    localparam int DRAIN_CYCLES = 45;
    localparam int HOLD_CYCLES  = 600;
    localparam int STALL_LIMIT  = 3000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in                  i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out                 o_out_data;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DW-1:0]        i_cfg_wdata;

    // Local copy of the configuration registers and pending expectations.
    logic [DW-1:0] cfg_shadow [NUM_REGS];
    t_out          expected_results [$];
    int            error_count;
    bit            gaps_on;
    bit            hold_req;

    tsukamoto_fuzzy_inference dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Membership grade of one ramp, Q1.16 with one as 2^16.
    function automatic logic [GW-1:0] ramp_grade(logic [DW-1:0] x, logic [DW-1:0] lo,
                                                 logic [DW-1:0] hi, bit rising);
        logic [63:0] num;
        if (x <= lo) return rising ? '0 : GRADE_ONE;
        if (x >= hi) return rising ? GRADE_ONE : '0;
        num = rising ? 64'(x - lo) : 64'(hi - x);
        return GW'((num << GF) / 64'(hi - lo));
    endfunction

    // Rule strengths and the weighted-average production for one beat.
    function automatic t_out predict_production(t_in x);
        t_out          r;
        logic [GW-1:0] df, dr, ss, sp;
        logic [127:0]  rs [4];
        logic [127:0]  zs [4];
        logic [127:0]  pmin, pmax, span, num, den, quo;
        df = ramp_grade(x.demand, cfg_shadow[REG_DEMAND_LOW], cfg_shadow[REG_DEMAND_HIGH], 0);
        dr = ramp_grade(x.demand, cfg_shadow[REG_DEMAND_LOW], cfg_shadow[REG_DEMAND_HIGH], 1);
        ss = ramp_grade(x.stock, cfg_shadow[REG_STOCK_LOW], cfg_shadow[REG_STOCK_HIGH], 0);
        sp = ramp_grade(x.stock, cfg_shadow[REG_STOCK_LOW], cfg_shadow[REG_STOCK_HIGH], 1);
        r.strength_fall_plenty = (df < sp) ? df : sp;
        r.strength_fall_scarce = (df < ss) ? df : ss;
        r.strength_rise_plenty = (dr < sp) ? dr : sp;
        r.strength_rise_scarce = (dr < ss) ? dr : ss;
        rs[0] = 128'(r.strength_fall_plenty);
        rs[1] = 128'(r.strength_fall_scarce);
        rs[2] = 128'(r.strength_rise_plenty);
        rs[3] = 128'(r.strength_rise_scarce);
        den = rs[0] + rs[1] + rs[2] + rs[3];
        r.weight_zero = (den == 0);
        r.production  = '0;
        if (den != 0) begin
            pmin = 128'(cfg_shadow[REG_PROD_MIN]) << GF;
            pmax = 128'(cfg_shadow[REG_PROD_MAX]) << GF;
            // Falling rules start at the max end, rising rules at the min end.
            if (cfg_shadow[REG_PROD_MAX] >= cfg_shadow[REG_PROD_MIN]) begin
                span  = 128'(cfg_shadow[REG_PROD_MAX] - cfg_shadow[REG_PROD_MIN]);
                zs[0] = pmax - span * rs[0];
                zs[1] = pmax - span * rs[1];
                zs[2] = pmin + span * rs[2];
                zs[3] = pmin + span * rs[3];
            end else begin
                span  = 128'(cfg_shadow[REG_PROD_MIN] - cfg_shadow[REG_PROD_MAX]);
                zs[0] = pmax + span * rs[0];
                zs[1] = pmax + span * rs[1];
                zs[2] = pmin - span * rs[2];
                zs[3] = pmin - span * rs[3];
            end
            num = zs[0] * rs[0] + zs[1] * rs[1] + zs[2] * rs[2] + zs[3] * rs[3];
            den = den << GF;
            quo = (num + (den >> 1)) / den;
            r.production = (quo > 128'(16'hFFFF)) ? '1 : DW'(quo);
        end
        return r;
    endfunction

    // Write all six registers in consecutive cycles; the engine must be empty.
    task automatic load_config(input logic [DW-1:0] v [NUM_REGS]);
        for (int k = 0; k < NUM_REGS; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(k);
            i_cfg_wdata <= v[k];
            cfg_shadow[k] = v[k];
            @(posedge i_clk);
        end
        // An index past the last register must leave everything unchanged.
        i_cfg_index <= CFG_IDX_W'(NUM_REGS + 1);
        i_cfg_wdata <= DW'($urandom());
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one beat and wait until the engine takes it.
    task automatic send_beat(input logic [DW-1:0] dem, input logic [DW-1:0] stk);
        t_in beat;
        int  gap;
        beat.demand = dem;
        beat.stock  = stk;
        gap = gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(predict_production(beat));
    endtask

    // Stop offering and let every outstanding result come back.
    task automatic drain;
        i_in_valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // A value near one of the breakpoints half the time, between them or anywhere otherwise.
    function automatic logic [DW-1:0] pick_value(logic [DW-1:0] lo, logic [DW-1:0] hi);
        logic [DW-1:0] base;
        case ($urandom_range(0, 3))
            0: return DW'($urandom());
            1: base = lo;
            2: base = hi;
            default: return (lo < hi) ? DW'($urandom_range(lo, hi)) : DW'($urandom());
        endcase
        return base + DW'($urandom_range(0, 6)) - DW'(3);
    endfunction

    task automatic send_random(input int count);
        for (int k = 0; k < count; k++)
            send_beat(pick_value(cfg_shadow[REG_DEMAND_LOW], cfg_shadow[REG_DEMAND_HIGH]),
                      pick_value(cfg_shadow[REG_STOCK_LOW], cfg_shadow[REG_STOCK_HIGH]));
    endtask

    // Reset values: ramp ends, one step inside, midpoints and field extremes.
    task automatic test_reset_values;
        logic [DW-1:0] dem [7] = '{16'd0, 16'd500, 16'd501, 16'd3000, 16'd5999, 16'd6000,
                                   16'hFFFF};
        logic [DW-1:0] stk [3] = '{16'd0, 16'd500, 16'hFFFF};
        foreach (dem[i]) send_beat(dem[i], stk[i % 3]);
        send_beat(16'd3250, 16'd200);
        send_beat(16'd3250, 16'd201);
        send_beat(16'd3250, 16'd799);
        send_beat(16'd3250, 16'd800);
        drain();
    endtask

    // Equal and reversed breakpoints, reversed and flat production ranges.
    task automatic test_degenerate_config;
        logic [DW-1:0] v [NUM_REGS];
        v = '{16'd1000, 16'd1000, 16'd5000, 16'd100, 16'd9000, 16'd3000};
        load_config(v);
        send_beat(16'd1000, 16'd100);
        send_beat(16'd1001, 16'd5000);
        send_beat(16'd0, 16'd3000);
        send_beat(16'hFFFF, 16'hFFFF);
        drain();
        v = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0};
        load_config(v);
        send_beat(16'd0, 16'hFFFF);
        send_beat(16'd1, 16'hFFFE);
        send_beat(16'h8000, 16'h7FFF);
        drain();
        v = '{16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd7, 16'd7};
        load_config(v);
        send_beat(16'hFFFF, 16'd0);
        send_beat(16'h1234, 16'hFFFF);
        drain();
    endtask

    // Random register settings and traffic clustered around the breakpoints.
    task automatic test_random_configs(input int phases, input int per_phase);
        logic [DW-1:0] v [NUM_REGS];
        logic [DW-1:0] a, b;
        for (int p = 0; p < phases; p++) begin
            for (int k = 0; k < NUM_REGS; k += 2) begin
                a = DW'($urandom());
                b = DW'($urandom());
                // Mostly ordered pairs, sometimes reversed or tiny spans.
                case ($urandom_range(0, 3))
                    0: begin v[k] = a; v[k+1] = b; end
                    1: begin v[k] = a; v[k+1] = a + DW'($urandom_range(0, 3)); end
                    default: begin v[k] = (a < b) ? a : b; v[k+1] = (a < b) ? b : a; end
                endcase
            end
            load_config(v);
            send_random(per_phase);
            drain();
        end
    endtask

    // Receiver holds off long enough for the engine to fill and stall its input.
    task automatic test_backpressure;
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        send_random(150);
        gaps_on = 1'b1;
        drain();
    endtask

    // Back-to-back beats with no stall on either side.
    task automatic test_full_rate;
        gaps_on = 1'b0;
        wait (!hold_req);
        hold_req = 1'b0;
        send_random(150);
        gaps_on = 1'b1;
        drain();
    endtask

    // Receiver stall pattern: a long hold on request, random holds otherwise, none while full-rate runs.
    initial begin
        i_out_stall = 1'b1;
        forever begin
            int n;
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                i_out_stall <= 1'b0;
            end else begin
                n = gaps_on ? $urandom_range(0, 9) : 0;
                i_out_stall <= (n > 0);
                repeat (n > 0 ? n - 1 : 0) @(posedge i_clk);
                if (n > 0) begin
                    @(posedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // Compare each accepted result beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("Result beat with nothing expected: %h", o_out_data);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.production !== want.production) begin
                    $error("production: expected %0d, got %0d",
                           want.production, o_out_data.production);
                    error_count++;
                end
                if (o_out_data.strength_fall_plenty !== want.strength_fall_plenty) begin
                    $error("strength_fall_plenty: expected %0d, got %0d",
                           want.strength_fall_plenty, o_out_data.strength_fall_plenty);
                    error_count++;
                end
                if (o_out_data.strength_fall_scarce !== want.strength_fall_scarce) begin
                    $error("strength_fall_scarce: expected %0d, got %0d",
                           want.strength_fall_scarce, o_out_data.strength_fall_scarce);
                    error_count++;
                end
                if (o_out_data.strength_rise_plenty !== want.strength_rise_plenty) begin
                    $error("strength_rise_plenty: expected %0d, got %0d",
                           want.strength_rise_plenty, o_out_data.strength_rise_plenty);
                    error_count++;
                end
                if (o_out_data.strength_rise_scarce !== want.strength_rise_scarce) begin
                    $error("strength_rise_scarce: expected %0d, got %0d",
                           want.strength_rise_scarce, o_out_data.strength_rise_scarce);
                    error_count++;
                end
                if (o_out_data.weight_zero !== want.weight_zero) begin
                    $error("weight_zero: expected %0d, got %0d",
                           want.weight_zero, o_out_data.weight_zero);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: too many cycles without a beat on either channel.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        error_count = 0;
        gaps_on     = 1'b1;
        hold_req    = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_wdata <= '0;
        cfg_shadow = '{RST_DEMAND_LOW, RST_DEMAND_HIGH, RST_STOCK_LOW, RST_STOCK_HIGH,
                       RST_PROD_MIN, RST_PROD_MAX};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_degenerate_config();
        test_random_configs(8, 190);
        test_backpressure();
        test_full_rate();

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/tfi_pkg.sv
hdl/tsukamoto_fuzzy_inference.sv
sim/tb_tsukamoto_fuzzy_inference.sv
